### design/csem_pkg.sv
// ============================================================================
// csem_pkg
// Shared types, codes and widths of the counting semaphore table.
// ============================================================================
`default_nettype none

package csem_pkg;

    // Field widths of the request and response items and of the semaphore entry
    localparam int OP_W   = 2;
    localparam int PROC_W = 6;
    localparam int SEM_W  = 5;
    localparam int VAL_W  = 16;
    localparam int STAT_W = 2;
    localparam int REFS_W = 10;

    // Default sizing of the table
    localparam int DEF_NUM_SEMS       = 32;
    localparam int DEF_SLOTS_PER_PROC = 8;
    localparam int DEF_NUM_PROCS      = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_GET   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
    localparam logic [OP_W-1:0] OP_DOWN  = 2'd2;
    localparam logic [OP_W-1:0] OP_UP    = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FAIL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BLOCK = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

    // Saturation limits
    localparam logic [REFS_W-1:0] REFS_MAX  = '1;
    localparam logic [VAL_W-1:0]  COUNT_MAX = '1;

    // One open slot of a process
    typedef struct packed {
        logic             valid;
        logic [SEM_W-1:0] idx;
    } slot_t;

    // One semaphore entry
    typedef struct packed {
        logic [VAL_W-1:0]  count;
        logic [REFS_W-1:0] refs;
    } sem_t;

    // Commands from the sequencer to the slot store
    typedef struct packed {
        logic scan_start;
        logic wr_en;
    } scan_ctl_t;

    // Status from the slot store to the sequencer
    typedef struct packed {
        logic clearing;
        logic done;
        logic free_found;
        logic held_found;
    } scan_res_t;

endpackage

`default_nettype wire

### design/csem_req_if.sv
// ============================================================================
// csem_req_if
// Request channel: valid/ready handshake with operation, process, index and
// initial value.
// ============================================================================
`default_nettype none

interface csem_req_if;
    logic                        valid;
    logic                        ready;
    logic [csem_pkg::OP_W-1:0]   req_type;
    logic [csem_pkg::PROC_W-1:0] process_id;
    logic [csem_pkg::SEM_W-1:0]  sem_index;
    logic [csem_pkg::VAL_W-1:0]  start_count;

    modport source (output valid, req_type, process_id, sem_index, start_count,
                    input ready);
    modport sink   (input valid, req_type, process_id, sem_index, start_count,
                    output ready);
endinterface

`default_nettype wire

### design/csem_rsp_if.sv
// ============================================================================
// csem_rsp_if
// Response channel: valid/ready handshake with status, returned index and
// wake flag.
// ============================================================================
`default_nettype none

interface csem_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [csem_pkg::STAT_W-1:0] status;
    logic [csem_pkg::SEM_W-1:0]  result_index;
    logic                        wake_waiters;

    modport source (output valid, status, result_index, wake_waiters, input ready);
    modport sink   (input valid, status, result_index, wake_waiters, output ready);
endinterface

`default_nettype wire

### design/csem_slot_scan.sv
// ============================================================================
// csem_slot_scan
// Open-slot store: one memory row of slots per process, a clearing sweep
// after reset, and a scan that finds the first free slot and the first slot
// holding a given semaphore.
// ============================================================================
`default_nettype none

module csem_slot_scan #(
    parameter int SLOTS_PER_PROC = csem_pkg::DEF_SLOTS_PER_PROC,
    parameter int NUM_PROCS      = csem_pkg::DEF_NUM_PROCS,
    localparam int KW = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire csem_pkg::scan_ctl_t         ctl,
    input  wire logic [csem_pkg::PROC_W-1:0] proc,
    input  wire logic [csem_pkg::SEM_W-1:0]  sem,
    input  wire logic [KW-1:0]               wr_k,
    input  wire csem_pkg::slot_t             wr_data,
    output csem_pkg::scan_res_t              res,
    output logic [KW-1:0]                    free_k,
    output logic [KW-1:0]                    held_k
);
    import csem_pkg::*;

    localparam int SLOT_DEPTH = NUM_PROCS * SLOTS_PER_PROC;
    localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam logic [KW-1:0]      K_LAST = KW'(SLOTS_PER_PROC - 1);
    localparam logic [SLOT_AW-1:0] A_LAST = SLOT_AW'(SLOT_DEPTH - 1);

    slot_t slot_ram [SLOT_DEPTH];
    slot_t slot_rdata_reg;

    logic               clr_busy_reg;
    logic [SLOT_AW-1:0] clr_addr_reg;
    logic               scan_busy_reg;
    logic [KW-1:0]      rd_k_reg;
    logic               pend_reg;
    logic               pend_last_reg;
    logic [KW-1:0]      pend_k_reg;
    logic               done_reg;
    logic               free_found_reg;
    logic               held_found_reg;
    logic [KW-1:0]      free_k_reg;
    logic [KW-1:0]      held_k_reg;

    logic [SLOT_AW-1:0] base;
    logic [SLOT_AW-1:0] rd_addr;
    logic [SLOT_AW-1:0] wr_addr;
    logic               wr_we;
    slot_t              wr_d;
    logic               hit_free;
    logic               hit_held;

    // Form the row base of the process and the port addresses
    assign base    = SLOT_AW'(int'(proc) * SLOTS_PER_PROC);
    assign rd_addr = base + SLOT_AW'(rd_k_reg);
    assign wr_addr = clr_busy_reg ? clr_addr_reg : base + SLOT_AW'(wr_k);
    assign wr_we   = clr_busy_reg || ctl.wr_en;
    assign wr_d    = clr_busy_reg ? slot_t'('0) : wr_data;

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_we)
        begin
            slot_ram[wr_addr] <= wr_d;
        end
        if (scan_busy_reg)
        begin
            slot_rdata_reg <= slot_ram[rd_addr];
        end
    end

    // Match the returned slot against the free and held conditions
    assign hit_free = pend_reg && !slot_rdata_reg.valid && !free_found_reg;
    assign hit_held = pend_reg && slot_rdata_reg.valid && (slot_rdata_reg.idx == sem)
                      && !held_found_reg;

    // Sweep and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            scan_busy_reg  <= 1'b0;
            rd_k_reg       <= '0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            done_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            held_found_reg <= 1'b0;
        end
        else
        begin
            // Clear every slot once after reset
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == A_LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            pend_reg      <= scan_busy_reg;
            pend_last_reg <= scan_busy_reg && (rd_k_reg == K_LAST);
            done_reg      <= pend_reg && pend_last_reg;

            if (hit_free)
            begin
                free_found_reg <= 1'b1;
            end
            if (hit_held)
            begin
                held_found_reg <= 1'b1;
            end

            // Walk the row one slot per cycle
            if (ctl.scan_start)
            begin
                scan_busy_reg  <= 1'b1;
                rd_k_reg       <= '0;
                free_found_reg <= 1'b0;
                held_found_reg <= 1'b0;
            end
            else if (scan_busy_reg)
            begin
                if (rd_k_reg == K_LAST)
                begin
                    scan_busy_reg <= 1'b0;
                end
                else
                begin
                    rd_k_reg <= rd_k_reg + 1'b1;
                end
            end
        end
    end

    // Hold slot positions of the matches
    always_ff @(posedge clk)
    begin
        pend_k_reg <= rd_k_reg;
        if (hit_free)
        begin
            free_k_reg <= pend_k_reg;
        end
        if (hit_held)
        begin
            held_k_reg <= pend_k_reg;
        end
    end

    assign res.clearing   = clr_busy_reg;
    assign res.done       = done_reg;
    assign res.free_found = free_found_reg;
    assign res.held_found = held_found_reg;
    assign free_k         = free_k_reg;
    assign held_k         = held_k_reg;

endmodule

`default_nettype wire

### design/counting_semaphore_table.sv
// ============================================================================
// counting_semaphore_table
// Hardware table of counting semaphores with per-process open slots.
// ============================================================================
// After reset the block sweeps the open-slot memory, one slot per cycle,
// through all NUM_PROCS * SLOTS_PER_PROC slots (512 at the default sizing), and
// takes no request until the sweep ends. It works on one request at a time and
// returns one response item per request. Get and close walk the process's row
// of slots through the slot memory's single read port, one slot per cycle, then
// read the semaphore entry and write it back with the response. Down, up and
// out-of-range requests skip the walk and go straight to the entry read. A
// finished response waits in an output register; write-back holds while that
// register is full and not taken, and the next request is accepted the cycle
// after the previous one is written back.
// Down on a zero count answers would-block; up at the maximum count answers
// count-overflow; wake_waiters marks an up that lifted the count from zero.
// ============================================================================
`default_nettype none

module counting_semaphore_table #(
    parameter int NUM_SEMS       = csem_pkg::DEF_NUM_SEMS,
    parameter int SLOTS_PER_PROC = csem_pkg::DEF_SLOTS_PER_PROC,
    parameter int NUM_PROCS      = csem_pkg::DEF_NUM_PROCS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    csem_req_if.sink    req,
    csem_rsp_if.source  rsp
);
    import csem_pkg::*;

    localparam int KW     = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1;
    localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SEMRD = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Request held for the duration of its work
    logic [OP_W-1:0]   op_reg;
    logic [PROC_W-1:0] proc_reg;
    logic [SEM_W-1:0]  sem_reg;
    logic [VAL_W-1:0]  init_reg;
    logic              in_range_reg;

    // Semaphore memory with per-entry valid bits
    sem_t              sem_ram [NUM_SEMS];
    sem_t              sem_rdata_reg;
    logic              sem_rvld_reg;
    logic [NUM_SEMS-1:0] sem_vld_reg;
    logic [SEM_AW-1:0] sem_addr;

    // Output register
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [SEM_W-1:0]  ridx_reg;
    logic              wake_reg;

    logic              in_ready;
    logic              accept;
    logic              in_range_in;
    logic              scan_need;
    logic              exec_go;

    scan_ctl_t         ctl;
    scan_res_t         res;
    logic [KW-1:0]     free_k;
    logic [KW-1:0]     held_k;
    logic [KW-1:0]     wr_k;
    slot_t             wr_data;
    logic              slot_we;

    logic [VAL_W-1:0]  cur_cnt;
    logic [REFS_W-1:0] cur_refs;
    logic [STAT_W-1:0] st;
    logic [SEM_W-1:0]  ridx;
    logic              wake;
    logic              sem_we;
    sem_t              sem_wd;

    // Accept a request only when idle and the sweep is over
    assign in_ready    = (state_reg == S_IDLE) && !res.clearing;
    assign accept      = req.valid && in_ready;
    assign req.ready   = in_ready;
    assign in_range_in = (int'(req.sem_index) < NUM_SEMS) &&
                         (int'(req.process_id) < NUM_PROCS);
    assign scan_need   = in_range_in && (req.req_type inside {OP_GET, OP_CLOSE});
    assign exec_go     = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign sem_addr    = SEM_AW'(sem_reg);

    assign ctl.scan_start = accept && scan_need;
    assign ctl.wr_en      = exec_go && slot_we;

    csem_slot_scan #(
        .SLOTS_PER_PROC (SLOTS_PER_PROC),
        .NUM_PROCS      (NUM_PROCS)
    ) u_slot_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .proc    (proc_reg),
        .sem     (sem_reg),
        .wr_k    (wr_k),
        .wr_data (wr_data),
        .res     (res),
        .free_k  (free_k),
        .held_k  (held_k)
    );

    // Sequence one request through scan, entry read and write-back
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = scan_need ? S_SCAN : S_SEMRD;
                end
            end
            S_SCAN:
            begin
                if (res.done)
                begin
                    state_next = S_SEMRD;
                end
            end
            S_SEMRD:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req.req_type;
            proc_reg     <= req.process_id;
            sem_reg      <= req.sem_index;
            init_reg     <= req.start_count;
            in_range_reg <= in_range_in;
        end
    end

    // Semaphore memory: read in the entry-read state, write on completion
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SEMRD) && in_range_reg)
        begin
            sem_rdata_reg <= sem_ram[sem_addr];
            sem_rvld_reg  <= sem_vld_reg[sem_addr];
        end
        if (exec_go && sem_we)
        begin
            sem_ram[sem_addr] <= sem_wd;
        end
    end

    // Mark entries written since reset; others read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sem_vld_reg <= '0;
        end
        else if (exec_go && sem_we)
        begin
            sem_vld_reg[sem_addr] <= 1'b1;
        end
    end

    // Decide the outcome and the write-backs
    always_comb
    begin
        cur_cnt  = sem_rvld_reg ? sem_rdata_reg.count : '0;
        cur_refs = sem_rvld_reg ? sem_rdata_reg.refs  : '0;
        st       = ST_FAIL;
        ridx     = '0;
        wake     = 1'b0;
        sem_we   = 1'b0;
        sem_wd   = '{count: cur_cnt, refs: cur_refs};
        slot_we  = 1'b0;
        wr_k     = free_k;
        wr_data  = '{valid: 1'b1, idx: sem_reg};
        if (in_range_reg)
        begin
            case (op_reg)
                OP_GET:
                begin
                    if (res.free_found && (cur_refs != REFS_MAX))
                    begin
                        st      = ST_OK;
                        ridx    = sem_reg;
                        sem_we  = 1'b1;
                        sem_wd.refs = cur_refs + 1'b1;
                        if (cur_refs == '0)
                        begin
                            sem_wd.count = init_reg;
                        end
                        slot_we = 1'b1;
                    end
                end
                OP_CLOSE:
                begin
                    if ((cur_refs != '0) && res.held_found)
                    begin
                        st          = ST_OK;
                        sem_we      = 1'b1;
                        sem_wd.refs = cur_refs - 1'b1;
                        slot_we     = 1'b1;
                        wr_k        = held_k;
                        wr_data     = '0;
                    end
                end
                OP_DOWN:
                begin
                    if (cur_refs != '0)
                    begin
                        if (cur_cnt == '0)
                        begin
                            st = ST_BLOCK;
                        end
                        else
                        begin
                            st           = ST_OK;
                            sem_we       = 1'b1;
                            sem_wd.count = cur_cnt - 1'b1;
                        end
                    end
                end
                OP_UP:
                begin
                    if (cur_refs != '0)
                    begin
                        if (cur_cnt == COUNT_MAX)
                        begin
                            st = ST_OVF;
                        end
                        else
                        begin
                            st           = ST_OK;
                            wake         = (cur_cnt == '0);
                            sem_we       = 1'b1;
                            sem_wd.count = cur_cnt + 1'b1;
                        end
                    end
                end
                default:
                begin
                    st = ST_FAIL;
                end
            endcase
        end
    end

    // Output register: load on completion, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            status_reg <= st;
            ridx_reg   <= ridx;
            wake_reg   <= wake;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.result_index = ridx_reg;
    assign rsp.wake_waiters = wake_reg;

endmodule

`default_nettype wire

### design/csem_checker.sv
// ============================================================================
// csem_checker
// Port-level checks of the counting semaphore table, bound to the top level.
// ============================================================================
`default_nettype none

module csem_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [csem_pkg::STAT_W-1:0] status,
    input wire logic [csem_pkg::SEM_W-1:0]  result_index,
    input wire logic                        wake_waiters
);
    import csem_pkg::*;

    // A wake is only reported by a successful up
    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wake_waiters |-> status == ST_OK)
        else $error("wake_waiters without ok status");

    // A nonzero index is only returned by a successful get
    a_ridx_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_index != '0) |-> status == ST_OK)
        else $error("result_index set on a failed item");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("back-to-back accept");

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind counting_semaphore_table csem_checker u_csem_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .status       (rsp.status),
    .result_index (rsp.result_index),
    .wake_waiters (rsp.wake_waiters)
);

`default_nettype wire

### tb/counting_semaphore_table_tb.sv
// ============================================================================
// counting_semaphore_table_tb
// Self-checking bench for the semaphore table. A short table of directed
// requests covers the corner cases: unopened semaphores, count overflow,
// would-block, wake on an up from zero, a full slot row and a close without a
// held slot. Random traffic follows. Every response is checked against a fixed
// value or an in-bench table prediction. Both channels idle in random bursts,
// and once the response side holds off long enough to stall the requests.
// ============================================================================
`timescale 1ns / 100ps

module counting_semaphore_table_tb;

    import csem_pkg::*;

    localparam int NSEMS      = DEF_NUM_SEMS;
    localparam int NSLOTS     = DEF_SLOTS_PER_PROC;
    localparam int NPROCS     = DEF_NUM_PROCS;
    localparam int RAND_ITEMS = 600;
    localparam int CALM_ITEMS = 100;
    localparam int HOLD_LEN   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 30;

    // One response item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEM_W-1:0]  ridx;
        logic              wake;
    } sem_rsp_t;

    // One row of the directed table
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [PROC_W-1:0] pid;
        logic [SEM_W-1:0]  sem;
        logic [VAL_W-1:0]  init;
        bit                fixed;
        sem_rsp_t          rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;

    csem_req_if req_ch ();
    csem_rsp_if rsp_ch ();

    counting_semaphore_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the table state
    logic [VAL_W-1:0]  mir_count [NSEMS];
    logic [REFS_W-1:0] mir_refs  [NSEMS];
    logic              mir_slot_valid [NPROCS*NSLOTS];
    logic [SEM_W-1:0]  mir_slot_sem   [NPROCS*NSLOTS];

    sem_rsp_t pending_rsp [$];
    dir_row_t dir_rows [$];

    int  err_cnt;
    int  mismatch_cnt;
    int  items_sent;
    int  rsp_seen;
    int  n_ok, n_fail, n_block, n_ovf, n_wake;
    bit  idle_on;
    bit  hold_req;
    bit  hold_done;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one request to the mirror and return its response
    function automatic sem_rsp_t predict_access(input logic [OP_W-1:0] op,
                                                input logic [PROC_W-1:0] pid,
                                                input logic [SEM_W-1:0] sem,
                                                input logic [VAL_W-1:0] init);
        sem_rsp_t r;
        int       base;
        int       hit;
        r.status = ST_FAIL;
        r.ridx   = '0;
        r.wake   = 1'b0;
        base     = int'(pid) * NSLOTS;
        hit      = -1;
        case (op)
            OP_GET:
            begin
                for (int k = NSLOTS - 1; k >= 0; k--)
                    if (!mir_slot_valid[base+k])
                        hit = k;
                if (hit >= 0 && mir_refs[sem] != REFS_MAX)
                begin
                    if (mir_refs[sem] == '0)
                        mir_count[sem] = init;
                    mir_refs[sem]++;
                    mir_slot_valid[base+hit] = 1'b1;
                    mir_slot_sem[base+hit]   = sem;
                    r.status = ST_OK;
                    r.ridx   = sem;
                end
            end
            OP_CLOSE:
            begin
                for (int k = NSLOTS - 1; k >= 0; k--)
                    if (mir_slot_valid[base+k] && mir_slot_sem[base+k] == sem)
                        hit = k;
                if (mir_refs[sem] != '0 && hit >= 0)
                begin
                    mir_slot_valid[base+hit] = 1'b0;
                    mir_slot_sem[base+hit]   = '0;
                    mir_refs[sem]--;
                    r.status = ST_OK;
                end
            end
            OP_DOWN:
            begin
                if (mir_refs[sem] != '0)
                begin
                    if (mir_count[sem] == '0)
                        r.status = ST_BLOCK;
                    else
                    begin
                        mir_count[sem]--;
                        r.status = ST_OK;
                    end
                end
            end
            default:
            begin
                if (mir_refs[sem] != '0)
                begin
                    if (mir_count[sem] == COUNT_MAX)
                        r.status = ST_OVF;
                    else
                    begin
                        r.wake = (mir_count[sem] == '0);
                        mir_count[sem]++;
                        r.status = ST_OK;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input int pid, input int sem,
                           input int init, input bit fixed,
                           input logic [STAT_W-1:0] st, input int ridx, input bit wake);
        dir_row_t row;
        row.op         = op;
        row.pid        = pid[PROC_W-1:0];
        row.sem        = sem[SEM_W-1:0];
        row.init       = init[VAL_W-1:0];
        row.fixed      = fixed;
        row.rsp.status = st;
        row.rsp.ridx   = ridx[SEM_W-1:0];
        row.rsp.wake   = wake;
        dir_rows.push_back(row);
    endtask

    // Offer one request, optionally after a gap, and hold it until accepted
    task automatic offer_item(input logic [OP_W-1:0] op, input logic [PROC_W-1:0] pid,
                              input logic [SEM_W-1:0] sem, input logic [VAL_W-1:0] init);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= op;
        req_ch.process_id  <= pid;
        req_ch.sem_index   <= sem;
        req_ch.start_count <= init;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Compare one response item with the oldest pending one
    task automatic check_response(input sem_rsp_t got);
        sem_rsp_t want;
        rsp_seen++;
        if (pending_rsp.size() == 0)
        begin
            err_cnt++;
            $display("[%0t] response with nothing pending: status %0d idx %0d wake %0d",
                     $realtime, got.status, got.ridx, got.wake);
            return;
        end
        want = pending_rsp.pop_front();
        if (got !== want)
        begin
            err_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("[%0t] mismatch on response %0d: want st %0d idx %0d wake %0d, got st %0d idx %0d wake %0d",
                         $realtime, rsp_seen, want.status, want.ridx, want.wake,
                         got.status, got.ridx, got.wake);
        end
        case (got.status)
            ST_OK:    n_ok++;
            ST_FAIL:  n_fail++;
            ST_BLOCK: n_block++;
            default:  n_ovf++;
        endcase
        if (got.wake)
            n_wake++;
    endtask

    // Response side: sample, then pick ready for the next cycle
    initial
    begin
        int stall_left;
        int hold_left;
        sem_rsp_t got;
        stall_left   = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.ridx   = rsp_ch.result_index;
                got.wake   = rsp_ch.wake_waiters;
                check_response(got);
            end
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && rst_n && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
                break;
        end
        $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
        $display("** counting_semaphore_table: FAILED **");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic [OP_W-1:0]   op;
        logic [PROC_W-1:0] pid;
        logic [SEM_W-1:0]  sem;
        logic [VAL_W-1:0]  init;
        sem_rsp_t          pred;
        int                roll;
        int                held [$];

        err_cnt      = 0;
        mismatch_cnt = 0;
        items_sent   = 0;
        rsp_seen     = 0;
        n_ok = 0; n_fail = 0; n_block = 0; n_ovf = 0; n_wake = 0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        hold_done = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = OP_GET;
        req_ch.process_id  = '0;
        req_ch.sem_index   = '0;
        req_ch.start_count = '0;
        for (int i = 0; i < NSEMS; i++)
        begin
            mir_count[i] = '0;
            mir_refs[i]  = '0;
        end
        for (int i = 0; i < NPROCS*NSLOTS; i++)
        begin
            mir_slot_valid[i] = 1'b0;
            mir_slot_sem[i]   = '0;
        end

        // Directed table: fixed rows carry their response, the rest use the mirror
        add_row(OP_DOWN,  0,  0, 0,       1, ST_FAIL,  0,  0);  // unopened
        add_row(OP_UP,    0, 31, 0,       1, ST_FAIL,  0,  0);
        add_row(OP_CLOSE, 63, 5, 0,       1, ST_FAIL,  0,  0);
        add_row(OP_GET,   0, 31, 'hFFFF,  1, ST_OK,   31,  0);  // first open at max
        add_row(OP_UP,    0, 31, 0,       1, ST_OVF,   0,  0);
        add_row(OP_DOWN,  0, 31, 0,       1, ST_OK,    0,  0);
        add_row(OP_UP,    5, 31, 0,       0, ST_OK,    0,  0);
        add_row(OP_UP,    5, 31, 0,       1, ST_OVF,   0,  0);
        add_row(OP_GET,  63,  0, 0,       1, ST_OK,    0,  0);  // first open at zero
        add_row(OP_DOWN, 63,  0, 0,       1, ST_BLOCK, 0,  0);
        add_row(OP_UP,   63,  0, 0,       1, ST_OK,    0,  1);  // wake from zero
        add_row(OP_DOWN,  1,  0, 0,       0, ST_OK,    0,  0);
        add_row(OP_CLOSE, 1,  0, 0,       1, ST_FAIL,  0,  0);  // not held
        add_row(OP_GET,   1,  0, 1234,    0, ST_OK,    0,  0);  // later open keeps count
        for (int i = 0; i < NSLOTS; i++)
            add_row(OP_GET, 2, 7, 'h5555, 0, ST_OK,    0,  0);  // repeated get
        add_row(OP_GET,   2,  7, 'h5555,  1, ST_FAIL,  0,  0);  // row full
        add_row(OP_CLOSE, 2,  7, 0,       0, ST_OK,    0,  0);
        add_row(OP_GET,   2,  7, 'hAAAA,  0, ST_OK,    0,  0);
        add_row(OP_CLOSE, 63, 0, 0,       0, ST_OK,    0,  0);
        add_row(OP_CLOSE, 1,  0, 0,       0, ST_OK,    0,  0);
        add_row(OP_DOWN,  0,  0, 0,       1, ST_FAIL,  0,  0);  // closed again

        // Hold reset, then release on an edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            offer_item(dir_rows[i].op, dir_rows[i].pid, dir_rows[i].sem, dir_rows[i].init);
            pred = predict_access(dir_rows[i].op, dir_rows[i].pid, dir_rows[i].sem,
                                  dir_rows[i].init);
            pending_rsp.push_back(dir_rows[i].fixed ? dir_rows[i].rsp : pred);
        end

        // Random traffic on a small working set, with some wide-range noise
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 150)
                hold_req = 1'b1;
            if (n == RAND_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            pid = ($urandom_range(0, 3) == 0) ? PROC_W'($urandom_range(0, NPROCS - 1))
                                              : PROC_W'($urandom_range(0, 7));
            sem = ($urandom_range(0, 3) == 0) ? SEM_W'($urandom_range(0, NSEMS - 1))
                                              : SEM_W'($urandom_range(0, 5));
            case ($urandom_range(0, 5))
                0:       init = '0;
                1:       init = 16'd1;
                2:       init = COUNT_MAX;
                3:       init = COUNT_MAX - 16'd1;
                default: init = VAL_W'($urandom_range(0, 65535));
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 28)
                op = OP_GET;
            else if (roll < 56)
                op = OP_CLOSE;
            else if (roll < 78)
                op = OP_DOWN;
            else
                op = OP_UP;
            // Mostly close a semaphore that the process holds
            if (op == OP_CLOSE && $urandom_range(0, 99) < 85)
            begin
                held.delete();
                for (int k = 0; k < NSLOTS; k++)
                    if (mir_slot_valid[int'(pid)*NSLOTS+k])
                        held.push_back(mir_slot_sem[int'(pid)*NSLOTS+k]);
                if (held.size() > 0)
                    sem = SEM_W'(held[$urandom_range(0, held.size() - 1)]);
            end
            offer_item(op, pid, sem, init);
            pending_rsp.push_back(predict_access(op, pid, sem, init));
        end
        req_ch.valid <= 1'b0;

        // Drain, then keep watching for stray responses before the final check
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
            err_cnt++;

        $display("Sent %0d requests (directed and random), checked %0d responses.",
                 items_sent, rsp_seen);
        $display("Status mix: ok %0d, fail %0d, would-block %0d, overflow %0d, wakes %0d.",
                 n_ok, n_fail, n_block, n_ovf, n_wake);
        if (err_cnt == 0)
            $display("** counting_semaphore_table: PASSED **");
        else
        begin
            $display("%0d errors, %0d mismatches", err_cnt, mismatch_cnt);
            $display("** counting_semaphore_table: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
design/csem_pkg.sv
design/csem_req_if.sv
design/csem_rsp_if.sv
design/csem_slot_scan.sv
design/counting_semaphore_table.sv
design/csem_checker.sv
tb/counting_semaphore_table_tb.sv
